/* design/itds_pkg.sv */
// Package for the include tag delimiter scan: sizes, reset values of the
// tag registers, register index and segment kind codes, tag length clamp.
// No dependencies.
package itds_pkg;

   // Longest tag and largest file
   localparam int MaxTagBytes  = 8;
   localparam int MaxFileBytes = 10485760;

   // Derived widths
   localparam int TagWidth      = 8 * MaxTagBytes;
   localparam int TagLenWidth   = 4;
   localparam int TagIdxWidth   = (MaxTagBytes > 1) ? $clog2(MaxTagBytes) : 1;
   localparam int PosWidth      = $clog2(MaxFileBytes + 1);
   localparam int SegWidth      = 24;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = TagWidth;

   // Reset tags: "<!--#" and "-->", first byte in the low bits
   localparam logic [TagWidth-1:0]    StartTagReset = TagWidth'(64'h0000_0023_2D2D_213C);
   localparam logic [TagLenWidth-1:0] StartLenReset = TagLenWidth'(5);
   localparam logic [TagWidth-1:0]    EndTagReset   = TagWidth'(64'h0000_0000_003E_2D2D);
   localparam logic [TagLenWidth-1:0] EndLenReset   = TagLenWidth'(3);

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_START_TAG,
      CSR_START_LEN,
      CSR_END_TAG,
      CSR_END_LEN
   } csr_index_type;

   typedef enum logic {
      SEG_TEXT,
      SEG_DIRECTIVE
   } seg_kind_type;

   // Tag length in use: zero acts as one, above the maximum acts as the maximum
   function automatic logic [TagLenWidth-1:0] clamp_len(input logic [TagLenWidth-1:0] v);
      logic [TagLenWidth-1:0] r;
      if (v == '0) begin
         r = TagLenWidth'(1);
      end else if (v > TagLenWidth'(MaxTagBytes)) begin
         r = TagLenWidth'(MaxTagBytes);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

/* design/include_tag_delimiter_scan.sv */
// Include tag delimiter scan: splits a byte stream into text and directive
// body segments. Depends on itds_pkg.
//
// The block takes one file byte per transaction and gives at most one segment
// per byte, in the cycle after the byte is taken. A new byte is accepted every
// cycle; the only limit is the single output register, so req_tready drops
// only while a segment waits on a stalled rsp_tready. Per byte, the newest
// bytes are compared in parallel against the start or end tag (whichever is
// sought), and the tag length set in the registers (1 to 8 bytes) picks the
// compared bytes. Segments are reported when a tag completes: text before a
// start tag (only when not empty), directive body before an end tag. The byte
// marked req_tlast flushes remaining text, drops an open directive and returns
// the scan state to its start. Bytes beyond the file size limit are ignored.
// The user must write csr_* registers only while the block is idle (unchecked).
module include_tag_delimiter_scan (
   input  logic                                  clock,
   input  logic                                  reset,
   // Byte stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] data_byte
   input  logic                                  req_tlast,   // last_byte
   // Segment stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [2*itds_pkg::SegWidth-1:0]       rsp_tdata,   // seg_offset, seg_len
   output logic                                  rsp_tuser,   // seg_kind
   // Register writes
   input  logic                                  csr_we,
   input  logic [itds_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [itds_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import itds_pkg::*;

   // Configuration registers
   logic [TagWidth-1:0]    start_tag_ff;
   logic [TagLenWidth-1:0] start_len_ff;
   logic [TagWidth-1:0]    end_tag_ff;
   logic [TagLenWidth-1:0] end_len_ff;

   // Scan state
   logic [7:0]             recent_ff [MaxTagBytes];
   logic [7:0]             recent_in [MaxTagBytes];
   logic                   in_dir_ff, in_dir_in;
   logic [PosWidth-1:0]    pos_ff, pos_in;
   logic [PosWidth-1:0]    seg_start_ff, seg_start_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   seg_kind_type           kind_ff, kind_in;
   logic [SegWidth-1:0]    off_ff, off_in;
   logic [SegWidth-1:0]    len_ff, len_in;

   // Step logic
   logic                   req_fire;
   logic                   room;
   logic [PosWidth-1:0]    pos_inc;
   logic [TagWidth-1:0]    tag_sel;
   logic [TagLenWidth-1:0] len_sel;
   logic [7:0]             win [MaxTagBytes];
   logic                   win_eq;
   logic                   far_enough;
   logic                   hit;
   logic [PosWidth-1:0]    body_len;
   logic                   hit_out;
   logic                   flush;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_tag_ff <= StartTagReset;
         start_len_ff <= StartLenReset;
         end_tag_ff   <= EndTagReset;
         end_len_ff   <= EndLenReset;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_TAG: start_tag_ff <= csr_wdata;
            CSR_START_LEN: start_len_ff <= csr_wdata[TagLenWidth-1:0];
            CSR_END_TAG:   end_tag_ff   <= csr_wdata;
            CSR_END_LEN:   end_len_ff   <= csr_wdata[TagLenWidth-1:0];
            default: ;
         endcase
      end
   end

   // Window of newest bytes after the shift, newest at index 0
   always_comb begin
      win[0] = req_tdata;
      for (int k = 1; k < MaxTagBytes; k++) begin
         win[k] = recent_ff[k-1];
      end
   end

   assign tag_sel = in_dir_ff ? end_tag_ff : start_tag_ff;
   assign len_sel = clamp_len(in_dir_ff ? end_len_ff : start_len_ff);
   assign room    = {1'b0, pos_ff} < (PosWidth+1)'(MaxFileBytes);
   assign pos_inc = pos_ff + PosWidth'(1);

   // Tag byte i sits len-1-i bytes back from the newest
   always_comb begin
      logic [TagIdxWidth-1:0] idx;
      win_eq = 1'b1;
      for (int i = 0; i < MaxTagBytes; i++) begin
         idx = TagIdxWidth'(len_sel - TagLenWidth'(1) - TagLenWidth'(i));
         if (TagLenWidth'(i) < len_sel && win[idx] != tag_sel[8*i +: 8]) begin
            win_eq = 1'b0;
         end
      end
   end

   // Tag must lie wholly after the previous one
   assign far_enough = {1'b0, pos_inc} >= ({1'b0, seg_start_ff} + (PosWidth+1)'(len_sel));
   assign hit        = room && far_enough && win_eq;
   assign body_len   = pos_inc - PosWidth'(len_sel) - seg_start_ff;
   assign hit_out    = hit && (in_dir_ff || body_len != '0);

   // Next scan state and segment
   always_comb begin
      recent_in    = recent_ff;
      in_dir_in    = in_dir_ff;
      pos_in       = pos_ff;
      seg_start_in = seg_start_ff;
      if (room) begin
         recent_in = win;
         pos_in    = pos_inc;
      end
      if (hit) begin
         seg_start_in = pos_inc;
         in_dir_in    = !in_dir_ff;
      end
      flush = req_tlast && !in_dir_in && (pos_in > seg_start_in) && !hit_out;

      kind_in = in_dir_ff ? SEG_DIRECTIVE : SEG_TEXT;
      off_in  = SegWidth'(seg_start_ff);
      len_in  = SegWidth'(body_len);
      if (!hit_out) begin
         kind_in = SEG_TEXT;
         len_in  = SegWidth'(pos_in - seg_start_in);
      end

      // End of file: start over
      if (req_tlast) begin
         for (int k = 0; k < MaxTagBytes; k++) begin
            recent_in[k] = '0;
         end
         in_dir_in    = 1'b0;
         pos_in       = '0;
         seg_start_in = '0;
      end

      if (req_fire && (hit_out || flush)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MaxTagBytes; k++) begin
            recent_ff[k] <= '0;
         end
         in_dir_ff    <= 1'b0;
         pos_ff       <= '0;
         seg_start_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            recent_ff    <= recent_in;
            in_dir_ff    <= in_dir_in;
            pos_ff       <= pos_in;
            seg_start_ff <= seg_start_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Segment payload
   always_ff @(posedge clock) begin
      if (req_fire && (hit_out || flush)) begin
         kind_ff <= kind_in;
         off_ff  <= off_in;
         len_ff  <= len_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {len_ff, off_ff};

   // Checks
   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> pos_ff == '0 && !in_dir_ff && seg_start_ff == '0)
      else $error("scan state not cleared after last byte");

   a_seg_order: assert property (@(posedge clock) disable iff (reset)
      seg_start_ff <= pos_ff)
      else $error("segment start beyond stream position");

   a_pos_cap: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} <= (PosWidth+1)'(MaxFileBytes))
      else $error("stream position beyond file limit");

   a_text_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == SEG_TEXT |-> len_ff != '0)
      else $error("empty text segment reported");

endmodule
